[rtl/core/nearest_neighbor_scaler_addr_unit_assert.svh]
// Assertion macros shared by the scaler address unit.
`ifndef NEAREST_NEIGHBOR_SCALER_ADDR_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALER_ADDR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define NNSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define NNSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define NNSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NNSA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/nnsa_pkg.sv]
// Types, constants and the microcode table of the scaler address unit.
package nnsa_pkg;

    // Fixed field widths.
    localparam int SIZE_W      = 13;
    localparam int ADDR_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 64;

    // Default limits.
    localparam int MAX_DIM_DEF     = 4096;
    localparam int BYTES_PER_PIXEL = 3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_SRC_BASE   = 3'd4,
        REG_DST_BASE   = 3'd5
    } cfg_index_t;

    // Sequencer steps.
    typedef enum logic [3:0] {
        ST_WAIT,
        ST_CHECK,
        ST_MUL_COL,
        ST_DIV_COL,
        ST_MUL_ROW,
        ST_DIV_ROW,
        ST_MUL_SRC,
        ST_ADD_SRC,
        ST_ADR_SRC,
        ST_MUL_DST,
        ST_ADD_DST,
        ST_ADR_DST,
        ST_EMIT
    } step_t;

    // Datapath operations.
    typedef enum logic [2:0] {
        OP_TAKE,
        OP_CHECK,
        OP_MUL,
        OP_DIV,
        OP_ADD,
        OP_ADDR,
        OP_EMIT
    } op_t;

    // Operand set for the shared multiplier, divider and adder.
    typedef enum logic [1:0] {
        SEL_COL,
        SEL_ROW,
        SEL_SRC,
        SEL_DST
    } sel_t;

    // Branch conditions; when true the sequencer takes the jump target.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_REQ,
        COND_BAD_SIZE,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    // One control word.
    typedef struct packed {
        op_t   op;
        sel_t  sel;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    // Microcode program, one control word per step.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        begin
            case (step)
                ST_WAIT:    w = '{OP_TAKE,  SEL_COL, COND_NO_REQ,   ST_WAIT,    ST_CHECK};
                ST_CHECK:   w = '{OP_CHECK, SEL_COL, COND_BAD_SIZE, ST_EMIT,    ST_MUL_COL};
                ST_MUL_COL: w = '{OP_MUL,   SEL_COL, COND_NEVER,    ST_WAIT,    ST_DIV_COL};
                ST_DIV_COL: w = '{OP_DIV,   SEL_COL, COND_DIV_BUSY, ST_DIV_COL, ST_MUL_ROW};
                ST_MUL_ROW: w = '{OP_MUL,   SEL_ROW, COND_NEVER,    ST_WAIT,    ST_DIV_ROW};
                ST_DIV_ROW: w = '{OP_DIV,   SEL_ROW, COND_DIV_BUSY, ST_DIV_ROW, ST_MUL_SRC};
                ST_MUL_SRC: w = '{OP_MUL,   SEL_SRC, COND_NEVER,    ST_WAIT,    ST_ADD_SRC};
                ST_ADD_SRC: w = '{OP_ADD,   SEL_SRC, COND_NEVER,    ST_WAIT,    ST_ADR_SRC};
                ST_ADR_SRC: w = '{OP_ADDR,  SEL_SRC, COND_NEVER,    ST_WAIT,    ST_MUL_DST};
                ST_MUL_DST: w = '{OP_MUL,   SEL_DST, COND_NEVER,    ST_WAIT,    ST_ADD_DST};
                ST_ADD_DST: w = '{OP_ADD,   SEL_DST, COND_NEVER,    ST_WAIT,    ST_ADR_DST};
                ST_ADR_DST: w = '{OP_ADDR,  SEL_DST, COND_NEVER,    ST_WAIT,    ST_EMIT};
                ST_EMIT:    w = '{OP_EMIT,  SEL_COL, COND_OUT_BUSY, ST_EMIT,    ST_WAIT};
                default:    w = '{OP_TAKE,  SEL_COL, COND_NEVER,    ST_WAIT,    ST_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

[rtl/core/nearest_neighbor_scaler_addr_unit.sv]
// Nearest-neighbor resize address generator driven by a microcoded sequencer.
//
// Channel   Direction  Contents
// s_axis    in         tdata[0] = restart (1 = go to pixel 0,0; 0 = next pixel)
// m_axis    out        tdata = src_addr, dst_addr; tlast = frame_last; tuser = size_error
// cfg       in         write-only registers: widths, heights and base addresses
//
// A request with usable sizes passes the size check, then for each axis a multiply and a
// bit-serial divide that takes one product bit per step, then the multiply, add and
// address steps for source and destination, and the final step loads the result
// register; a request with a zero or oversized dimension goes from the size check
// straight to the final step, and the next request waits until it has left. Reset clears the
// sequencer, the counters, the output valid and the configuration registers; the
// datapath registers are always loaded before they are read. A new request is taken
// while the previous result still waits on m_axis; the sequencer holds in its final step
// only until the output register frees up.

`include "nearest_neighbor_scaler_addr_unit_assert.svh"

module nearest_neighbor_scaler_addr_unit #(
    parameter int MAX_DIM = nnsa_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_wen,
    input  nnsa_pkg::cfg_index_t                 cfg_index,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // Request stream; tdata bits from 0: restart, then zero fill.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [nnsa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // Result stream; tdata bits from 0: src_addr[31:0], dst_addr[31:0].
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [nnsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    // tuser bits from 0: size_error.
    output logic                                 m_axis_tuser
);

    import nnsa_pkg::*;

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int PROD_W = CNT_W + SIZE_W;
    localparam int DCNT_W = $clog2(PROD_W);
    localparam int CMP_W  = (CNT_W + 1 > SIZE_W) ? CNT_W + 1 : SIZE_W;
    localparam logic [31:0] MAX_DIM_W = 32'(MAX_DIM);

    // Configuration registers.
    logic [SIZE_W-1:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [ADDR_W-1:0] src_base_reg, dst_base_reg;

    // Sequencer and datapath registers.
    step_t              step_reg, step_next;
    logic               restart_reg;
    logic [CNT_W-1:0]   dest_col_reg, dest_row_reg, src_col_reg, src_row_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SIZE_W-1:0]  rem_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;
    logic [ADDR_W-1:0]  src_addr_reg, dst_addr_reg;
    logic               last_reg, err_reg;

    // Output register.
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               out_last_reg, out_err_reg;

    ucode_t             uc;
    logic               in_accept, slot_free, bad_size, cond_true;
    logic [CNT_W-1:0]   mul_a;
    logic [SIZE_W-1:0]  mul_b, divisor;
    logic [PROD_W-1:0]  mul_prod;
    logic [SIZE_W:0]    trial;
    logic               q_bit;
    logic [PROD_W-1:0]  prod_shift;
    logic [CMP_W-1:0]   col_inc, row_inc, row_adv;
    logic [CNT_W-1:0]   col_adv_n, row_adv_n;
    logic               col_wrap, row_wrap;
    logic [ADDR_W-1:0]  pix32, addr_sum;
    logic               last_now;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= '0;
            src_height_reg <= '0;
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
            src_base_reg   <= '0;
            dst_base_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SRC_BASE:   src_base_reg   <= cfg_wdata[ADDR_W-1:0];
                REG_DST_BASE:   dst_base_reg   <= cfg_wdata[ADDR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control word of the current step and handshake terms.
    assign uc            = ucode_rom(step_reg);
    assign s_axis_tready = (uc.op == OP_TAKE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // A size is unusable when it is zero or above the maximum dimension.
    assign bad_size = (src_width_reg == '0) || (src_height_reg == '0) ||
                      (dst_width_reg == '0) || (dst_height_reg == '0) ||
                      (32'(src_width_reg) > MAX_DIM_W) || (32'(src_height_reg) > MAX_DIM_W) ||
                      (32'(dst_width_reg) > MAX_DIM_W) || (32'(dst_height_reg) > MAX_DIM_W);

    // Branch condition and next step.
    always_comb
    begin
        case (uc.cond)
            COND_NEVER:    cond_true = 1'b0;
            COND_NO_REQ:   cond_true = !in_accept;
            COND_BAD_SIZE: cond_true = bad_size;
            COND_DIV_BUSY: cond_true = (div_cnt_reg != '0);
            COND_OUT_BUSY: cond_true = !slot_free;
            default:       cond_true = 1'b0;
        endcase
        step_next = cond_true ? uc.jump : uc.next;
    end

    // Operand selection for the shared multiplier and divider.
    always_comb
    begin
        case (uc.sel)
            SEL_COL:
            begin
                mul_a   = dest_col_reg;
                mul_b   = src_width_reg;
                divisor = dst_width_reg;
            end
            SEL_ROW:
            begin
                mul_a   = dest_row_reg;
                mul_b   = src_height_reg;
                divisor = dst_height_reg;
            end
            SEL_SRC:
            begin
                mul_a   = src_row_reg;
                mul_b   = src_width_reg;
                divisor = dst_width_reg;
            end
            SEL_DST:
            begin
                mul_a   = dest_row_reg;
                mul_b   = dst_width_reg;
                divisor = dst_height_reg;
            end
            default:
            begin
                mul_a   = dest_col_reg;
                mul_b   = src_width_reg;
                divisor = dst_width_reg;
            end
        endcase
    end

    assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // One restoring-division step: the dividend shifts out of the top of prod_reg
    // while quotient bits shift in at the bottom.
    assign trial      = {rem_reg, prod_reg[PROD_W-1]};
    assign q_bit      = (trial >= {1'b0, divisor});
    assign prod_shift = {prod_reg[PROD_W-2:0], q_bit};

    // Destination advance: column steps, rows wrap, frame wraps.
    assign col_inc   = CMP_W'(dest_col_reg) + CMP_W'(1);
    assign col_wrap  = (col_inc >= CMP_W'(dst_width_reg));
    assign row_inc   = CMP_W'(dest_row_reg) + CMP_W'(1);
    assign row_adv   = col_wrap ? row_inc : CMP_W'(dest_row_reg);
    assign row_wrap  = (row_adv >= CMP_W'(dst_height_reg));
    assign col_adv_n = (col_wrap || row_wrap) ? '0 : col_inc[CNT_W-1:0];
    assign row_adv_n = row_wrap ? '0 : row_adv[CNT_W-1:0];

    // Byte address from the pixel index held in prod_reg.
    assign pix32    = 32'(prod_reg);
    assign addr_sum = ((uc.sel == SEL_SRC) ? src_base_reg : dst_base_reg) +
                      pix32 * 32'(BYTES_PER_PIXEL);
    assign last_now = (CMP_W'(dest_col_reg) + CMP_W'(1) == CMP_W'(dst_width_reg)) &&
                      (CMP_W'(dest_row_reg) + CMP_W'(1) == CMP_W'(dst_height_reg));

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (uc.op == OP_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Destination counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_col_reg <= '0;
            dest_row_reg <= '0;
        end
        else if (uc.op == OP_CHECK)
        begin
            if (restart_reg)
            begin
                dest_col_reg <= '0;
                dest_row_reg <= '0;
            end
            else if (!bad_size)
            begin
                dest_col_reg <= col_adv_n;
                dest_row_reg <= row_adv_n;
            end
        end
    end

    // Datapath registers, driven by the current control word.
    always_ff @(posedge clk)
    begin
        case (uc.op)
            OP_TAKE:
            begin
                if (in_accept)
                begin
                    restart_reg <= s_axis_tdata[0];
                end
            end
            OP_CHECK:
            begin
                err_reg      <= bad_size;
                src_addr_reg <= '0;
                dst_addr_reg <= '0;
                last_reg     <= 1'b0;
            end
            OP_MUL:
            begin
                prod_reg    <= mul_prod;
                rem_reg     <= '0;
                div_cnt_reg <= DCNT_W'(PROD_W - 1);
            end
            OP_DIV:
            begin
                prod_reg    <= prod_shift;
                rem_reg     <= q_bit ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    if (uc.sel == SEL_COL)
                    begin
                        src_col_reg <= prod_shift[CNT_W-1:0];
                    end
                    else
                    begin
                        src_row_reg <= prod_shift[CNT_W-1:0];
                    end
                end
            end
            OP_ADD:
            begin
                prod_reg <= prod_reg +
                            PROD_W'((uc.sel == SEL_SRC) ? src_col_reg : dest_col_reg);
            end
            OP_ADDR:
            begin
                if (uc.sel == SEL_SRC)
                begin
                    src_addr_reg <= addr_sum;
                end
                else
                begin
                    dst_addr_reg <= addr_sum;
                    last_reg     <= last_now;
                end
            end
            OP_EMIT:
            begin
                if (slot_free)
                begin
                    out_data_reg <= {dst_addr_reg, src_addr_reg};
                    out_last_reg <= last_reg;
                    out_err_reg  <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_err_reg;

    // An accepted request always starts the size check next.
    `NNSA_ASSERT_NXT(a_take_then_check, clk, rst_n, in_accept, step_reg == ST_CHECK)
    // An error result carries no addresses and no frame end.
    `NNSA_ASSERT_IMP(a_err_clean, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        (m_axis_tdata == '0) && !m_axis_tlast)
    // Leaving the final step always presents a result.
    `NNSA_ASSERT_NXT(a_emit_valid, clk, rst_n, (uc.op == OP_EMIT) && slot_free,
        m_axis_tvalid && (step_reg == ST_WAIT))

endmodule

[verif/nn_scaler_addr_checker.sv]
// Checker for the scaler address unit: predicts each address pair and compares results.
module nn_scaler_addr_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  nnsa_pkg::cfg_index_t                 cfg_index,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    // Bits from 0: restart, then zero fill.
    input  logic [nnsa_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Bits from 0: src_addr[31:0], dst_addr[31:0].
    input  logic [nnsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 m_axis_tlast,
    // Bits from 0: size_error.
    input  logic                                 m_axis_tuser,
    output int                                   fail_count,
    output int                                   outstanding
);

    localparam int unsigned MAX_DIM = nnsa_pkg::MAX_DIM_DEF;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic        frame_last;
        logic        size_error;
    } pixel_addrs_t;

    // Shadow copies of the configuration registers.
    logic [12:0] src_width;
    logic [12:0] src_height;
    logic [12:0] dst_width;
    logic [12:0] dst_height;
    logic [31:0] src_base;
    logic [31:0] dst_base;

    // Current destination pixel.
    logic [11:0] cur_col;
    logic [11:0] cur_row;

    pixel_addrs_t pending_pixels[$];
    int results_seen;

    task automatic flag_error(input string msg);
        $display("ERROR result %0d: %s", results_seen, msg);
        fail_count++;
    endtask

    function automatic logic sizes_unusable();
        return src_width == 0 || src_height == 0 || dst_width == 0 || dst_height == 0 ||
               src_width > MAX_DIM || src_height > MAX_DIM ||
               dst_width > MAX_DIM || dst_height > MAX_DIM;
    endfunction

    // Step the destination cursor and work out the address pair for the new pixel.
    function automatic pixel_addrs_t next_pixel_addrs(input logic restart);
        pixel_addrs_t r;
        int unsigned col;
        int unsigned row;
        int unsigned scol;
        int unsigned srow;
        logic [31:0] spix;
        logic [31:0] dpix;
        r = '0;
        col = restart ? 0 : cur_col;
        row = restart ? 0 : cur_row;
        // Unusable sizes only honor a restart; an advance keeps the cursor.
        if (sizes_unusable())
        begin
            cur_col = col[11:0];
            cur_row = row[11:0];
            r.size_error = 1'b1;
            return r;
        end
        // Raster advance; a column or row beyond the current size ends the row or frame.
        if (!restart)
        begin
            if (col + 1 >= dst_width)
            begin
                col = 0;
                row = row + 1;
            end
            else
            begin
                col = col + 1;
            end
            if (row >= dst_height)
            begin
                row = 0;
                col = 0;
            end
        end
        cur_col = col[11:0];
        cur_row = row[11:0];
        // Exact floor(dest * src_size / dst_size) on each axis.
        scol = (col * src_width) / dst_width;
        srow = (row * src_height) / dst_height;
        spix = srow * src_width + scol;
        dpix = row * dst_width + col;
        r.src_addr = src_base + spix * nnsa_pkg::BYTES_PER_PIXEL;
        r.dst_addr = dst_base + dpix * nnsa_pkg::BYTES_PER_PIXEL;
        r.frame_last = (col + 1 == dst_width) && (row + 1 == dst_height);
        return r;
    endfunction

    // Register writes, result checks and request predictions, in that order.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_addrs_t want;
        pixel_addrs_t got;
        if (!rst_n)
        begin
            src_width = '0;
            src_height = '0;
            dst_width = '0;
            dst_height = '0;
            src_base = '0;
            dst_base = '0;
            cur_col = '0;
            cur_row = '0;
            fail_count = 0;
            results_seen = 0;
            pending_pixels.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    nnsa_pkg::REG_SRC_WIDTH:  src_width = cfg_wdata[12:0];
                    nnsa_pkg::REG_SRC_HEIGHT: src_height = cfg_wdata[12:0];
                    nnsa_pkg::REG_DST_WIDTH:  dst_width = cfg_wdata[12:0];
                    nnsa_pkg::REG_DST_HEIGHT: dst_height = cfg_wdata[12:0];
                    nnsa_pkg::REG_SRC_BASE:   src_base = cfg_wdata;
                    nnsa_pkg::REG_DST_BASE:   dst_base = cfg_wdata;
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.src_addr = m_axis_tdata[31:0];
                got.dst_addr = m_axis_tdata[63:32];
                got.frame_last = m_axis_tlast;
                got.size_error = m_axis_tuser;
                if (pending_pixels.size() == 0)
                begin
                    flag_error("result arrived with no request waiting");
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.src_addr !== want.src_addr)
                        flag_error($sformatf("src_addr %h, want %h", got.src_addr,
                                             want.src_addr));
                    if (got.dst_addr !== want.dst_addr)
                        flag_error($sformatf("dst_addr %h, want %h", got.dst_addr,
                                             want.dst_addr));
                    if (got.frame_last !== want.frame_last)
                        flag_error($sformatf("frame_last %b, want %b", got.frame_last,
                                             want.frame_last));
                    if (got.size_error !== want.size_error)
                        flag_error($sformatf("size_error %b, want %b", got.size_error,
                                             want.size_error));
                end
                results_seen++;
            end

            if (s_axis_tvalid && s_axis_tready)
                pending_pixels.push_back(next_pixel_addrs(s_axis_tdata[0]));

            outstanding <= pending_pixels.size();
        end
    end

endmodule

[verif/nearest_neighbor_scaler_addr_unit_tb.sv]
// Testbench top for the scaler address unit: clock, reset, stimulus and the verdict.
module nearest_neighbor_scaler_addr_unit_tb;

    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 70;
    localparam int TOTAL_REQUESTS = 950;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                 cfg_wen = 1'b0;
    nnsa_pkg::cfg_index_t                 cfg_index = nnsa_pkg::REG_SRC_WIDTH;
    logic [nnsa_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;

    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    // Bits from 0: restart, then zero fill.
    logic [nnsa_pkg::IN_DATA_W-1:0]       s_axis_tdata = '0;

    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    // Bits from 0: src_addr[31:0], dst_addr[31:0].
    logic [nnsa_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
    logic                                 m_axis_tlast;
    // Bits from 0: size_error.
    logic                                 m_axis_tuser;

    int fail_count;
    int outstanding;
    int requests_sent = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    const nnsa_pkg::cfg_index_t size_regs[4] = '{nnsa_pkg::REG_SRC_WIDTH,
                                                 nnsa_pkg::REG_SRC_HEIGHT,
                                                 nnsa_pkg::REG_DST_WIDTH,
                                                 nnsa_pkg::REG_DST_HEIGHT};
    const nnsa_pkg::cfg_index_t base_regs[2] = '{nnsa_pkg::REG_SRC_BASE,
                                                 nnsa_pkg::REG_DST_BASE};

    nearest_neighbor_scaler_addr_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    nn_scaler_addr_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: alternate ready runs and stalls of random length, some of them long.
    logic rx_ready_phase = 1'b0;
    int rx_phase_left = 0;
    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_ready_phase = !rx_ready_phase;
            if (rx_ready_phase)
                rx_phase_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                            : $urandom_range(1, 40);
            else
                rx_phase_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16)
                                                            : $urandom_range(1, 3);
        end
        rx_phase_left--;
        m_axis_tready <= rx_ready_phase;
    end

    // Give up when nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wen)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One register write; the caller lowers the write enable after its last write.
    task automatic write_reg(input nnsa_pkg::cfg_index_t idx, input logic [31:0] value);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic set_frame(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh,
                             input logic [31:0] sbase, input logic [31:0] dbase);
        write_reg(nnsa_pkg::REG_SRC_WIDTH, sw);
        write_reg(nnsa_pkg::REG_SRC_HEIGHT, sh);
        write_reg(nnsa_pkg::REG_DST_WIDTH, dw);
        write_reg(nnsa_pkg::REG_DST_HEIGHT, dh);
        write_reg(nnsa_pkg::REG_SRC_BASE, sbase);
        write_reg(nnsa_pkg::REG_DST_BASE, dbase);
        cfg_wen <= 1'b0;
    endtask

    // Present one request and hold it until accepted; bursts end in a random gap.
    task automatic send_request(input logic restart);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(nnsa_pkg::IN_DATA_W-1){1'b0}}, restart};
        do @(posedge clk); while (!s_axis_tready);
        requests_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_advances(input int n);
        repeat (n) send_request(1'b0);
    endtask

    // Stop requests and wait until every predicted result has been taken.
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // A new set of sizes and bases, then a frame-shaped run of requests.
    task automatic run_random_phase;
        int unsigned kind;
        int unsigned sizes[4];
        logic [31:0] bases[2];
        logic [31:0] value;
        int frame_pixels;
        int count;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            // Small frames so that frame ends and wraps come often.
            sizes[0] = $urandom_range(1, 12);
            sizes[1] = $urandom_range(1, 12);
            sizes[2] = $urandom_range(1, 8);
            sizes[3] = $urandom_range(1, 8);
            frame_pixels = sizes[2] * sizes[3];
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                case ($urandom_range(0, 2))
                    0: sizes[i] = 4096;
                    1: sizes[i] = 1;
                    default: sizes[i] = $urandom_range(1, 4096);
                endcase
            end
            frame_pixels = 0;
            // Some phases get an unusable size: zero or beyond the limit.
            if (kind >= 85)
                sizes[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 0
                                                                   : $urandom_range(4097, 8191);
        end
        for (int j = 0; j < 2; j++)
        begin
            case ($urandom_range(0, 3))
                0: bases[j] = '0;
                1: bases[j] = 32'hFFFF_FFFF - $urandom_range(0, 64);
                default: bases[j] = $urandom;
            endcase
        end

        // Most registers are rewritten; a skipped one keeps its old value.
        for (int i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                value = sizes[i];
                if ($urandom_range(0, 3) == 0)
                    value[31:13] = 19'($urandom);
                write_reg(size_regs[i], value);
            end
        end
        for (int j = 0; j < 2; j++)
            if ($urandom_range(0, 4) != 0)
                write_reg(base_regs[j], bases[j]);
        cfg_wen <= 1'b0;

        if (frame_pixels > 0)
            count = frame_pixels * 2 + $urandom_range(0, 6);
        else
            count = $urandom_range(5, 25);
        if (count > 80)
            count = 80;
        // Usually a fresh frame; otherwise the cursor carries over from the last setting.
        send_request($urandom_range(0, 4) == 0 ? 1'b0 : 1'b1);
        for (int n = 1; n < count; n++)
            send_request($urandom_range(0, 24) == 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Advance straight after reset, through the frame end and the wrap,
        // with both bases close to the top of the address space.
        set_frame(4096, 4096, 3, 2, 32'hFFFF_FFF0, 32'hFFFF_FFFA);
        send_advances(7);
        send_request(1'b1);

        // Zero and oversized dimensions.
        drain_results();
        write_reg(nnsa_pkg::REG_SRC_WIDTH, 32'd0);
        cfg_wen <= 1'b0;
        send_request(1'b0);
        send_request(1'b1);
        drain_results();
        write_reg(nnsa_pkg::REG_SRC_WIDTH, 32'h0000_1FFF);
        cfg_wen <= 1'b0;
        send_request(1'b0);

        // Largest destination, then a shrink mid-frame that ends the row and frame.
        drain_results();
        set_frame(1, 1, 4096, 4096, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(1'b1);
        send_advances(3);
        drain_results();
        write_reg(nnsa_pkg::REG_DST_WIDTH, 32'd2);
        write_reg(nnsa_pkg::REG_DST_HEIGHT, 32'd2);
        cfg_wen <= 1'b0;
        send_advances(3);

        // One-pixel destination: every pixel ends a frame.
        drain_results();
        set_frame(4096, 4096, 1, 1, 32'h8000_0000, 32'h0000_0000);
        send_advances(2);

        while (requests_sent < TOTAL_REQUESTS)
        begin
            drain_results();
            run_random_phase();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[nearest_neighbor_scaler_addr_unit.f]
+incdir+rtl/core
rtl/core/nnsa_pkg.sv
rtl/core/nearest_neighbor_scaler_addr_unit.sv
verif/nn_scaler_addr_checker.sv
verif/nearest_neighbor_scaler_addr_unit_tb.sv
